// ----- design/oal_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array list package
// Shared request codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oal_pkg;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND      = 3'd0,
    KIND_INSERT      = 3'd1,
    KIND_REMOVE_LAST = 3'd2,
    KIND_ERASE_IDX   = 3'd3,
    KIND_ERASE_VAL   = 3'd4,
    KIND_ERASE_ALL   = 3'd5,
    KIND_FIND        = 3'd6,
    KIND_CLEAR       = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_index;
    logic [COUNT_W-1:0] erased_count;
    logic [COUNT_W-1:0] fill_count;
    logic               is_empty;
  } result_t;

endpackage

// ----- design/oal_core.sv -----
// ----------------------------------------------------------------------------
// Ordered array list core
// Entry memory, element count and the sequencer that walks the memory for
// insert, erase, compaction and search requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oal_core import oal_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int DATA_W   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  kind_e            kind_i,
  input  logic [POS_W-1:0] position_i,
  input  logic [DATA_W-1:0] word_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output result_t          res_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic [DATA_W-1:0] entry_mem [CAPACITY];

  state_e            state_q, state_d;
  kind_e             kind_q;
  logic [CNT_W-1:0]  pos_q;
  logic [DATA_W-1:0] word_q;
  logic [CNT_W-1:0]  scan_q;
  logic [CNT_W-1:0]  end_q;
  logic              s2_valid_q;
  logic [CNT_W-1:0]  s2_idx_q;
  logic [DATA_W-1:0] rd_q;
  logic [CNT_W-1:0]  w_q;
  logic [DATA_W-1:0] hold_q;
  logic              found_q;
  logic [CNT_W-1:0]  fidx_q;
  logic [CNT_W-1:0]  count_q;
  result_t           res_q;

  logic [CW-1:0]     pos_x, cnt_x;
  logic              full, empty, ins_ok, erx_ok, scan_done, match;
  logic [CNT_W-1:0]  start_pos;

  logic              mem_we, mem_re, res_load, keep, hit;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              r_ok;
  logic [CNT_W-1:0]  r_found, r_erased, r_count;
  logic [CW-1:0]     r_found_x, r_erased_x, r_count_x;
  result_t           res_d;

  assign pos_x     = CW'(position_i);
  assign cnt_x     = CW'(count_q);
  assign full      = (count_q == CapCnt);
  assign empty     = (count_q == '0);
  assign ins_ok    = (pos_x <= cnt_x) && !full;
  assign erx_ok    = (pos_x < cnt_x);
  assign start_pos = (kind_i == KIND_INSERT || kind_i == KIND_ERASE_IDX)
                     ? pos_x[CNT_W-1:0] : '0;
  assign scan_done = (scan_q == end_q) && !s2_valid_q;
  assign match     = (rd_q == word_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_INSERT:    state_d = ins_ok ? ST_SCAN : ST_DONE;
            KIND_ERASE_IDX: state_d = erx_ok ? ST_SCAN : ST_DONE;
            KIND_ERASE_VAL,
            KIND_ERASE_ALL,
            KIND_FIND:      state_d = ST_SCAN;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory control and result formation.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = word_i;
    mem_re    = 1'b0;
    mem_raddr = scan_q[IDX_W-1:0];
    res_load  = 1'b0;
    r_ok      = 1'b0;
    r_found   = '0;
    r_erased  = '0;
    r_count   = count_q;
    keep      = 1'b0;
    hit       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_APPEND: begin
              res_load = 1'b1;
              if (!full) begin
                mem_we  = 1'b1;
                r_ok    = 1'b1;
                r_count = count_q + CNT_W'(1);
              end
            end
            KIND_INSERT: res_load = !ins_ok;
            KIND_REMOVE_LAST: begin
              res_load = 1'b1;
              if (!empty) begin
                r_ok    = 1'b1;
                r_count = count_q - CNT_W'(1);
              end
            end
            KIND_ERASE_IDX: res_load = !erx_ok;
            KIND_CLEAR: begin
              res_load = 1'b1;
              r_ok     = 1'b1;
              r_count  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_re = (scan_q != end_q) && (scan_q < count_q);
        if (s2_valid_q) begin
          case (kind_q)
            KIND_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = s2_idx_q[IDX_W-1:0];
              mem_wdata = (s2_idx_q == pos_q) ? word_q : hold_q;
            end
            KIND_ERASE_IDX: keep = (s2_idx_q != pos_q);
            KIND_ERASE_VAL: begin
              hit  = match && !found_q;
              keep = !hit;
            end
            KIND_ERASE_ALL: keep = !match;
            KIND_FIND:      hit  = match && !found_q;
            default: ;
          endcase
          if (keep) begin
            mem_we    = 1'b1;
            mem_waddr = w_q[IDX_W-1:0];
            mem_wdata = rd_q;
          end
        end
        if (scan_done) begin
          res_load = 1'b1;
          case (kind_q)
            KIND_INSERT: begin
              r_ok    = 1'b1;
              r_count = count_q + CNT_W'(1);
            end
            KIND_ERASE_IDX: begin
              r_ok    = 1'b1;
              r_count = count_q - CNT_W'(1);
            end
            KIND_ERASE_VAL: begin
              r_ok    = found_q;
              r_found = fidx_q;
              r_count = found_q ? (count_q - CNT_W'(1)) : count_q;
            end
            KIND_ERASE_ALL: begin
              r_ok     = 1'b1;
              r_erased = count_q - w_q;
              r_count  = w_q;
            end
            KIND_FIND: begin
              r_ok    = found_q;
              r_found = fidx_q;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign r_found_x  = CW'(r_found);
  assign r_erased_x = CW'(r_erased);
  assign r_count_x  = CW'(r_count);

  always_comb begin
    res_d.ok           = r_ok;
    res_d.found_index  = r_found_x[FOUND_W-1:0];
    res_d.erased_count = r_erased_x[COUNT_W-1:0];
    res_d.fill_count   = r_count_x[COUNT_W-1:0];
    res_d.is_empty     = (r_count == '0);
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= entry_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      s2_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        count_q <= r_count;
      end
      if (state_q == ST_IDLE) begin
        s2_valid_q <= 1'b0;
        found_q    <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        s2_valid_q <= (scan_q != end_q);
        if (hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      kind_q <= kind_i;
      word_q <= word_i;
      pos_q  <= start_pos;
      scan_q <= start_pos;
      w_q    <= start_pos;
      fidx_q <= '0;
      end_q  <= (kind_i == KIND_INSERT) ? (count_q + CNT_W'(1)) : count_q;
    end else if (state_q == ST_SCAN) begin
      if (scan_q != end_q) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      s2_idx_q <= scan_q;
      if (keep) begin
        w_q <= w_q + CNT_W'(1);
      end
      if (hit) begin
        fidx_q <= s2_idx_q;
      end
      if (s2_valid_q && kind_q == KIND_INSERT) begin
        hold_q <= rd_q;
      end
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

// ----- design/ordered_array_list_engine_unit.sv -----
// Append, remove last, clear and rejected requests form their result on acceptance, with no
// memory walk; walking requests read one entry per cycle on the entry memory port.
// Transactions are handled one at a time; the next is accepted once the result enters the
// output register, even while that result is still stalled.
// Reset: asynchronous and active low; the list comes up empty, memory contents are not cleared.
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity ordered list of words with append, insert, remove, erase,
// find and clear requests, one result transaction per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_array_list_engine_unit import oal_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int DATA_W   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic [FOUND_W-1:0] found_index_o,
  output logic [COUNT_W-1:0] erased_count_o,
  output logic [COUNT_W-1:0] fill_count_o,
  output logic               is_empty_o
);

  // The value word is zero-extended or truncated to the element width.
  localparam int VW = (DATA_W > VALUE_W) ? DATA_W : VALUE_W;

  logic [VW-1:0]     value_wide;
  logic [DATA_W-1:0] word;
  logic              core_idle, core_res_valid, res_take, start;
  result_t           core_res;

  logic    out_valid_q;
  result_t out_res_q;

  assign value_wide = VW'(value_i);
  assign word       = value_wide[DATA_W-1:0];

  // A request is taken only while the sequencer is idle; the output register
  // decouples the result side so one stalled result does not hold up the next request.
  assign in_stall_o = !core_idle;
  assign start      = in_valid_i && core_idle;

  oal_core #(
    .CAPACITY (CAPACITY),
    .DATA_W   (DATA_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_e'(kind_i)),
    .position_i  (position_i),
    .word_i      (word),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_take_i  (res_take),
    .res_o       (core_res)
  );

  // The finished result moves into the output register whenever that register
  // is empty or its current transaction completes in the same cycle.
  assign res_take = core_res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_res_q.ok;
  assign found_index_o  = out_res_q.found_index;
  assign erased_count_o = out_res_q.erased_count;
  assign fill_count_o   = out_res_q.fill_count;
  assign is_empty_o     = out_res_q.is_empty;

  // The sequencer handles one request at a time, so an accepted request
  // always blocks the input in the following cycle.
  a_accept_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A reported match index only comes with a successful request.
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_index_o != '0)) |-> ok_o)
    else $error("nonzero found index on a failed request");

  // Only erase-all reports a removal count, and it never fails.
  a_erased_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (erased_count_o == '0))
    else $error("removal count on a failed request");

  // With no truncation of the count, the empty flag agrees with the count.
  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (CAPACITY < 128)) |-> (is_empty_o == (fill_count_o == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

// ----- tb/tb_ordered_array_list_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Sends list requests through the valid/stall input channel and checks each
// result transaction against a shadow copy of the list kept in the bench.
// A short directed table runs first, then randomized traffic in phases.
// ----------------------------------------------------------------------------

module tb_ordered_array_list_engine_unit;
  import oal_pkg::*;

  localparam int LIST_CAP     = 64;
  localparam int WORD_W       = 32;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1600;
  localparam int LIMIT_CYCLES = 1_000_000;
  // The tail covers a walk over the whole list with margin, so it is long
  // enough for any stray result transaction to show up.
  localparam int TAIL_CYCLES  = LIST_CAP + 16;
  localparam int DIR_ROWS     = 25;

  // Traffic phases of the random part. The grow, shrink and uniform phases
  // bias the request mix so that the list is driven full, drained, or packed
  // with copies of a single word; the search phase draws the non-clear kinds evenly.
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_SEARCH,
    MIX_UNIFORM
  } traffic_e;

  // One row of the directed table. When has_res is set, res is the result
  // typed in by hand; otherwise the shadow list supplies the expectation.
  typedef struct {
    kind_e               kind;
    logic [POS_W-1:0]    pos;
    logic [VALUE_W-1:0]  val;
    bit                  has_res;
    result_t             res;
  } dir_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i         = '0;
  logic [POS_W-1:0]   position_i     = '0;
  logic [VALUE_W-1:0] value_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               ok_o;
  logic [FOUND_W-1:0] found_index_o;
  logic [COUNT_W-1:0] erased_count_o;
  logic [COUNT_W-1:0] fill_count_o;
  logic               is_empty_o;

  // Shadow copy of the list, updated when a request is accepted.
  logic [WORD_W-1:0]  shadow_list [LIST_CAP];
  int                 shadow_len = 0;

  // Results still owed by the block, oldest first.
  result_t            pending_results [$];

  int                 error_count     = 0;
  int                 results_checked = 0;
  int                 requests_sent   = 0;
  int                 rejected_count  = 0;
  int                 full_hits       = 0;
  int                 peak_fill       = 0;
  int                 cycle_count     = 0;
  int                 burst_left      = 0;

  dir_row_t           dir_table [DIR_ROWS];

  ordered_array_list_engine_unit #(
    .CAPACITY (LIST_CAP),
    .DATA_W   (WORD_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .found_index_o  (found_index_o),
    .erased_count_o (erased_count_o),
    .fill_count_o   (fill_count_o),
    .is_empty_o     (is_empty_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Removes one entry and closes the hole, as erase-at-index and
  // erase-value both do.
  function automatic void drop_entry(int idx);
    int i;
    for (i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
  endfunction

  // Applies one request to the shadow list and returns the result the
  // block must produce for it.
  function automatic result_t predict_list_op(kind_e k, logic [POS_W-1:0] p,
                                              logic [VALUE_W-1:0] v);
    result_t r;
    int      i;
    int      hit;
    int      keep;
    r    = '0;
    hit  = -1;
    keep = 0;
    case (k)
      KIND_APPEND: begin
        if (shadow_len < LIST_CAP) begin
          shadow_list[shadow_len] = v;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        // Inserting at the current size is the same as appending.
        if (int'(p) <= shadow_len && shadow_len < LIST_CAP) begin
          for (i = shadow_len; i > int'(p); i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[p] = v;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_LAST: begin
        if (shadow_len > 0) begin
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      KIND_ERASE_IDX: begin
        if (int'(p) < shadow_len) begin
          drop_entry(int'(p));
          r.ok = 1'b1;
        end
      end
      KIND_ERASE_VAL, KIND_FIND: begin
        for (i = 0; i < shadow_len && hit < 0; i++) begin
          if (shadow_list[i] == v) hit = i;
        end
        if (hit >= 0) begin
          r.ok          = 1'b1;
          r.found_index = FOUND_W'(hit);
          if (k == KIND_ERASE_VAL) drop_entry(hit);
        end
      end
      KIND_ERASE_ALL: begin
        // Compact in place, keeping the order of the survivors. This
        // request succeeds even when nothing matched.
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] != v) begin
            shadow_list[keep] = shadow_list[i];
            keep++;
          end
        end
        r.erased_count = COUNT_W'(shadow_len - keep);
        shadow_len     = keep;
        r.ok           = 1'b1;
      end
      default: begin
        shadow_len = 0;
        r.ok       = 1'b1;
      end
    endcase
    r.fill_count = COUNT_W'(shadow_len);
    r.is_empty   = (shadow_len == 0);
    return r;
  endfunction

  // Picks the request kind for the current traffic phase. A small share of
  // clears lands in every phase so that the list restarts now and then.
  function automatic kind_e pick_kind(traffic_e mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return KIND_CLEAR;
    case (mix)
      MIX_GROW: begin
        if (roll < 55) return KIND_APPEND;
        if (roll < 88) return KIND_INSERT;
        return kind_e'($urandom_range(2, 6));
      end
      MIX_SHRINK: begin
        // Some growth stays in the mix to keep material around to erase.
        if (roll < 15) return KIND_APPEND;
        if (roll < 30) return KIND_INSERT;
        if (roll < 45) return KIND_REMOVE_LAST;
        if (roll < 60) return KIND_ERASE_IDX;
        if (roll < 78) return KIND_ERASE_VAL;
        if (roll < 90) return KIND_ERASE_ALL;
        return KIND_FIND;
      end
      MIX_UNIFORM: begin
        if (roll < 80) return KIND_APPEND;
        if (roll < 90) return KIND_ERASE_ALL;
        return KIND_FIND;
      end
      default: begin
        return kind_e'($urandom_range(0, 6));
      end
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap.
  // Valid is never lowered on the step it is raised again.
  task automatic send_request(input kind_e k, input logic [POS_W-1:0] p,
                              input logic [VALUE_W-1:0] v, input bit has_res,
                              input result_t hand_res);
    result_t model_res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // About one burst in five is a long one, so that stretches without gaps occur.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= k;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if ((k == KIND_APPEND || k == KIND_INSERT) && shadow_len == LIST_CAP) full_hits++;
    model_res = predict_list_op(k, p, v);
    if (!model_res.ok) rejected_count++;
    if (shadow_len > peak_fill) peak_fill = shadow_len;
    requests_sent++;
    pending_results.insert(pending_results.size(), has_res ? hand_res : model_res);
  endtask

  // Holds the sender off until every owed result has come back. At least
  // one clock edge passes, so the next request starts on a later step.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side. Outputs are sampled at the rising edge, before the block's
  // own updates for that edge land. The stall pattern is redrawn periodically
  // among no stall, scattered random stalls and stall runs of random length.
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    bit      hold;
    int      stall_mode;
    int      stall_left;
    int      stall_epoch;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, actual ok=%0d fill=%0d", $time, ok_o,
                   fill_count_o);
        end else begin
          want = pending_results.pop_front();
          check_field("ok", want.ok, ok_o);
          check_field("found_index", want.found_index, found_index_o);
          check_field("erased_count", want.erased_count, erased_count_o);
          check_field("fill_count", want.fill_count, fill_count_o);
          check_field("is_empty", want.is_empty, is_empty_o);
          results_checked++;
        end
      end
      stall_epoch++;
      if (stall_epoch % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        hold = 1'b1;
      end else if (stall_mode == 1) begin
        hold = ($urandom_range(0, 2) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
        hold       = 1'b1;
      end else begin
        hold = 1'b0;
      end
      out_stall_i <= hold;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                 j;
    int                 done_items;
    int                 block_len;
    int                 pool_size;
    traffic_e           mix;
    kind_e              k;
    logic [POS_W-1:0]   p;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] value_pool [8];

    // Directed part. It starts on the empty list right after reset, so
    // every rejection on an empty list comes first, then a short list
    // built from the all-zero and all-one words, out-of-range positions
    // up to the widest one the field allows, and the erase kinds.
    dir_table = '{
      '{KIND_REMOVE_LAST, 7'd0,   32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_ERASE_IDX,   7'd0,   32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_ERASE_VAL,   7'd0,   32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_FIND,        7'd0,   32'hFFFF_FFFF, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_ERASE_ALL,   7'd0,   32'h0000_0000, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_INSERT,      7'd1,   32'h0000_0001, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_INSERT,      7'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd1, 1'b0}},
      '{KIND_APPEND,      7'd0,   32'h0000_0000, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd2, 1'b0}},
      '{KIND_APPEND,      7'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd3, 1'b0}},
      '{KIND_FIND,        7'd0,   32'h0000_0000, 1'b1, '{1'b1, 6'd1, 7'd0, 7'd3, 1'b0}},
      '{KIND_INSERT,      7'd3,   32'h5555_5555, 1'b0, '0},
      '{KIND_INSERT,      7'd1,   32'hAAAA_AAAA, 1'b0, '0},
      '{KIND_INSERT,      7'd127, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd5, 1'b0}},
      '{KIND_ERASE_IDX,   7'd5,   32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd5, 1'b0}},
      '{KIND_ERASE_IDX,   7'd127, 32'h0000_0000, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd5, 1'b0}},
      '{KIND_FIND,        7'd0,   32'h1234_5678, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd5, 1'b0}},
      '{KIND_ERASE_VAL,   7'd0,   32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_ERASE_ALL,   7'd0,   32'hFFFF_FFFF, 1'b0, '0},
      '{KIND_ERASE_IDX,   7'd1,   32'h0000_0000, 1'b0, '0},
      '{KIND_REMOVE_LAST, 7'd0,   32'h0000_0000, 1'b0, '0},
      '{KIND_CLEAR,       7'd0,   32'h0000_0000, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd0, 1'b1}},
      '{KIND_APPEND,      7'd0,   32'h0000_0007, 1'b0, '0},
      '{KIND_APPEND,      7'd0,   32'h0000_0007, 1'b0, '0},
      '{KIND_ERASE_ALL,   7'd0,   32'h0000_0007, 1'b1, '{1'b1, 6'd0, 7'd2, 7'd0, 1'b1}},
      '{KIND_CLEAR,       7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b1, 6'd0, 7'd0, 7'd0, 1'b1}}
    };

    // Reset is asserted from time zero and released once, at a clock edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (j = 0; j < DIR_ROWS; j++) begin
      send_request(dir_table[j].kind, dir_table[j].pos, dir_table[j].val,
                   dir_table[j].has_res, dir_table[j].res);
    end

    // The sender waits here until the block has answered everything.
    drain_results();

    // Random part, in phases of random length. Values mostly come from a
    // small pool so that find and erase requests actually hit; positions
    // mostly fall within or just past the current size, the rest anywhere
    // in the field.
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      mix       = traffic_e'($urandom_range(0, 3));
      block_len = $urandom_range(20, 120);
      pool_size = (mix == MIX_UNIFORM) ? 1 : $urandom_range(1, 6);
      for (j = 0; j < pool_size; j++) begin
        case ($urandom_range(0, 9))
          0:       value_pool[j] = '0;
          1:       value_pool[j] = '1;
          default: value_pool[j] = $urandom();
        endcase
      end
      if ($urandom_range(0, 3) == 0) drain_results();
      // A uniform phase starts from an empty list, so it can end with every
      // entry holding the same word and an erase-all that empties a full list.
      if (mix == MIX_UNIFORM) begin
        send_request(KIND_CLEAR, POS_W'($urandom_range(0, 127)), $urandom(), 1'b0, '0);
        done_items++;
      end
      for (j = 0; j < block_len && done_items < RANDOM_ITEMS; j++) begin
        k = pick_kind(mix);
        p = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 127))
                                        : POS_W'($urandom_range(0, shadow_len));
        v = (mix != MIX_UNIFORM && $urandom_range(0, 4) == 0)
            ? VALUE_W'($urandom()) : value_pool[$urandom_range(0, pool_size - 1)];
        send_request(k, p, v, 1'b0, '0);
        done_items++;
      end
    end

    // Wind down: wait for the owed results, then idle long enough for any
    // extra result transaction to appear.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d list requests in %0d cycles: %0d rejected, %0d against a full list,",
             requests_sent, cycle_count, rejected_count, full_hits);
    $display("peak fill %0d of %0d; %0d results compared, %0d mismatches.", peak_fill,
             LIST_CAP, results_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
